/* sv/dynamic_priority_aging_scheduler_assert.svh */
// Assertion macros for the aging scheduler.
// Taken in by dpas_ctrl, which checks its own control logic.
`ifndef DYNAMIC_PRIORITY_AGING_SCHEDULER_ASSERT_SVH
`define DYNAMIC_PRIORITY_AGING_SCHEDULER_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define DPAS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define DPAS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/dpas_pkg.sv */
// Shared types, constants and helper functions of the aging scheduler.
// No dependencies; used by dpas_list, dpas_ctrl and the top level.
`timescale 1ns / 1ps

package dpas_pkg;

  localparam int MAX_WAITING = 16;
  localparam int IDX_W       = $clog2(MAX_WAITING);
  localparam int CNT_W       = $clog2(MAX_WAITING + 1);
  localparam int ID_W        = 8;
  localparam int PRIO_W      = 6;
  localparam int REM_W       = 16;
  localparam int SLICE_W     = 8;

  localparam logic [PRIO_W-1:0] PRIO_CAP = PRIO_W'(40);

  localparam logic CMD_TICK = 1'b0;
  localparam logic CMD_ADD  = 1'b1;

  localparam logic [1:0] REG_RUN_PENALTY  = 2'd0;
  localparam logic [1:0] REG_WAIT_BONUS   = 2'd1;
  localparam logic [1:0] REG_SLICE_LENGTH = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [REM_W-1:0]  rem;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   idx;
    entry_t data;
  } list_wr_t;

  typedef struct packed {
    logic [PRIO_W-1:0]  run_penalty;
    logic [PRIO_W-1:0]  wait_bonus;
    logic [SLICE_W-1:0] slice_length;
  } cfg_t;

  typedef struct packed {
    logic              accepted;
    logic              done_valid;
    logic [ID_W-1:0]   done_id;
    logic              run_valid;
    logic [ID_W-1:0]   run_id;
    logic [PRIO_W-1:0] run_priority;
    logic [REM_W-1:0]  run_remaining;
    logic [4:0]        waiting_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TICK,
    ST_SLICE,
    ST_SCAN,
    ST_PICKED,
    ST_TAKE,
    ST_SHIFT,
    ST_RUN,
    ST_AGE,
    ST_FLUSH
  } state_t;

  // Why a pick is under way; selects where the sequencer resumes.
  typedef enum logic [1:0] {
    PH_START,
    PH_SLICE,
    PH_FINISH
  } phase_t;

  function automatic logic [PRIO_W-1:0] age_prio(input logic [PRIO_W-1:0] p,
                                                 input logic [PRIO_W-1:0] bonus);
    logic [PRIO_W:0] s;
    s = {1'b0, p} + {1'b0, bonus};
    return (s > {1'b0, PRIO_CAP}) ? PRIO_CAP : s[PRIO_W-1:0];
  endfunction

  function automatic logic [PRIO_W-1:0] sub_floor(input logic [PRIO_W-1:0] p,
                                                  input logic [PRIO_W-1:0] pen);
    return (p < pen) ? '0 : p - pen;
  endfunction

endpackage

/* sv/dpas_list.sv */
// Ready list storage: one entry per waiting task, one read and one write port.
// Depends on dpas_pkg for the entry and write-port types.
`timescale 1ns / 1ps

module dpas_list (
  input  logic              clk,
  input  dpas_pkg::idx_t    rd_idx,
  output dpas_pkg::entry_t  rd_data,
  input  dpas_pkg::list_wr_t wr
);

  dpas_pkg::entry_t mem_r [dpas_pkg::MAX_WAITING];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.idx] <= wr.data;
    end
  end

  assign rd_data = mem_r[rd_idx];

endmodule

/* sv/dpas_ctrl.sv */
// Scheduler sequencer: running task, slice counter and list walks for
// pick, shift and aging. Depends on dpas_pkg and the assertion header.
`timescale 1ns / 1ps
`include "dynamic_priority_aging_scheduler_assert.svh"

module dpas_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_cmd,
  input  logic [dpas_pkg::ID_W-1:0]    in_task_id,
  input  logic [dpas_pkg::PRIO_W-1:0]  in_start_priority,
  input  logic [dpas_pkg::REM_W-1:0]   in_burst_time,
  input  dpas_pkg::cfg_t               cfg,
  output logic                         res_valid,
  input  logic                         res_ready,
  output dpas_pkg::res_t               res,
  output dpas_pkg::idx_t               list_rd_idx,
  input  dpas_pkg::entry_t             list_rd,
  output dpas_pkg::list_wr_t           list_wr
);

  dpas_pkg::state_t                    state_r, state_nxt;
  dpas_pkg::phase_t                    phase_r, phase_nxt;
  dpas_pkg::idx_t                      ptr_r, ptr_nxt;
  dpas_pkg::idx_t                      best_idx_r, best_idx_nxt;
  logic [dpas_pkg::PRIO_W-1:0]         best_prio_r, best_prio_nxt;
  dpas_pkg::cnt_t                      total_r, total_nxt;
  logic                                busy_r, busy_nxt;
  dpas_pkg::entry_t                    run_r, run_nxt;
  dpas_pkg::entry_t                    hold_r, hold_nxt;
  logic                                swap_r, swap_nxt;
  logic [dpas_pkg::SLICE_W-1:0]        slice_r, slice_nxt;
  logic                                acc_r, acc_nxt;
  logic                                done_r, done_nxt;
  logic [dpas_pkg::ID_W-1:0]           done_id_r, done_id_nxt;

  logic [dpas_pkg::SLICE_W-1:0]        slice_len;
  dpas_pkg::cnt_t                      ptr_inc;
  logic                                last;

  assign slice_len = (cfg.slice_length == '0) ? dpas_pkg::SLICE_W'(1) : cfg.slice_length;
  assign ptr_inc   = dpas_pkg::CNT_W'(ptr_r) + dpas_pkg::CNT_W'(1);
  assign last      = (ptr_inc >= total_r);
  assign in_stall  = (state_r != dpas_pkg::ST_IDLE) || !rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dpas_pkg::ST_IDLE;
      phase_r <= dpas_pkg::PH_START;
      ptr_r   <= '0;
      total_r <= '0;
      busy_r  <= 1'b0;
      run_r   <= '0;
      slice_r <= '0;
      swap_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      ptr_r   <= ptr_nxt;
      total_r <= total_nxt;
      busy_r  <= busy_nxt;
      run_r   <= run_nxt;
      slice_r <= slice_nxt;
      swap_r  <= swap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    best_idx_r  <= best_idx_nxt;
    best_prio_r <= best_prio_nxt;
    hold_r      <= hold_nxt;
    acc_r       <= acc_nxt;
    done_r      <= done_nxt;
    done_id_r   <= done_id_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    ptr_nxt       = ptr_r;
    best_idx_nxt  = best_idx_r;
    best_prio_nxt = best_prio_r;
    total_nxt     = total_r;
    busy_nxt      = busy_r;
    run_nxt       = run_r;
    hold_nxt      = hold_r;
    swap_nxt      = swap_r;
    slice_nxt     = slice_r;
    acc_nxt       = acc_r;
    done_nxt      = done_r;
    done_id_nxt   = done_id_r;
    list_rd_idx   = ptr_r;
    list_wr       = '0;
    res_valid     = 1'b0;

    case (state_r)
      dpas_pkg::ST_IDLE: begin
        if (in_valid && rst_n) begin
          acc_nxt     = 1'b1;
          done_nxt    = 1'b0;
          done_id_nxt = '0;
          if (in_cmd == dpas_pkg::CMD_ADD) begin
            state_nxt = dpas_pkg::ST_FLUSH;
            if (total_r < dpas_pkg::CNT_W'(dpas_pkg::MAX_WAITING)) begin
              list_wr.en        = 1'b1;
              list_wr.idx       = dpas_pkg::IDX_W'(total_r);
              list_wr.data.id   = in_task_id;
              list_wr.data.prio = in_start_priority;
              // a burst of zero counts as one tick of work
              list_wr.data.rem  = (in_burst_time == '0) ? dpas_pkg::REM_W'(1)
                                                         : in_burst_time;
              total_nxt         = total_r + dpas_pkg::CNT_W'(1);
            end else begin
              acc_nxt = 1'b0;
            end
          end else begin
            state_nxt = dpas_pkg::ST_TICK;
          end
        end
      end

      dpas_pkg::ST_TICK: begin
        if (busy_r) begin
          state_nxt = dpas_pkg::ST_SLICE;
        end else if (total_r == '0) begin
          slice_nxt = slice_len;
          state_nxt = dpas_pkg::ST_FLUSH;
        end else begin
          phase_nxt = dpas_pkg::PH_START;
          ptr_nxt   = '0;
          state_nxt = dpas_pkg::ST_SCAN;
        end
      end

      dpas_pkg::ST_SLICE: begin
        if (slice_r != '0) begin
          slice_nxt = slice_r - dpas_pkg::SLICE_W'(1);
          state_nxt = dpas_pkg::ST_RUN;
        end else begin
          slice_nxt = slice_len - dpas_pkg::SLICE_W'(1);
          if (total_r != '0) begin
            phase_nxt = dpas_pkg::PH_SLICE;
            ptr_nxt   = '0;
            state_nxt = dpas_pkg::ST_SCAN;
          end else begin
            state_nxt = dpas_pkg::ST_RUN;
          end
        end
      end

      dpas_pkg::ST_SCAN: begin
        // strict compare keeps the earliest entry on a tie
        if (ptr_r == '0 || list_rd.prio > best_prio_r) begin
          best_idx_nxt  = ptr_r;
          best_prio_nxt = list_rd.prio;
        end
        if (last) begin
          state_nxt = dpas_pkg::ST_PICKED;
        end else begin
          ptr_nxt = ptr_r + dpas_pkg::IDX_W'(1);
        end
      end

      dpas_pkg::ST_PICKED: begin
        case (phase_r)
          dpas_pkg::PH_SLICE: begin
            // the running task wins only with a strictly higher priority
            if (best_prio_r >= run_r.prio) begin
              swap_nxt  = 1'b1;
              state_nxt = dpas_pkg::ST_TAKE;
            end else begin
              state_nxt = dpas_pkg::ST_RUN;
            end
          end
          default: begin
            swap_nxt  = 1'b0;
            state_nxt = dpas_pkg::ST_TAKE;
          end
        endcase
      end

      dpas_pkg::ST_TAKE: begin
        list_rd_idx = best_idx_r;
        hold_nxt    = run_r;
        run_nxt     = list_rd;
        busy_nxt    = 1'b1;
        ptr_nxt     = best_idx_r;
        state_nxt   = dpas_pkg::ST_SHIFT;
      end

      dpas_pkg::ST_SHIFT: begin
        if (!last) begin
          // close the gap one entry per cycle
          list_rd_idx  = ptr_r + dpas_pkg::IDX_W'(1);
          list_wr.en   = 1'b1;
          list_wr.idx  = ptr_r;
          list_wr.data = list_rd;
          ptr_nxt      = ptr_r + dpas_pkg::IDX_W'(1);
        end else begin
          if (swap_r) begin
            list_wr.en   = 1'b1;
            list_wr.idx  = ptr_r;
            list_wr.data = hold_r;
          end else begin
            total_nxt = total_r - dpas_pkg::CNT_W'(1);
          end
          case (phase_r)
            dpas_pkg::PH_START:  state_nxt = dpas_pkg::ST_SLICE;
            dpas_pkg::PH_SLICE:  state_nxt = dpas_pkg::ST_RUN;
            dpas_pkg::PH_FINISH: begin
              ptr_nxt   = '0;
              state_nxt = dpas_pkg::ST_AGE;
            end
            default:             state_nxt = dpas_pkg::ST_RUN;
          endcase
        end
      end

      dpas_pkg::ST_RUN: begin
        ptr_nxt = '0;
        if (run_r.rem <= dpas_pkg::REM_W'(1)) begin
          done_nxt    = 1'b1;
          done_id_nxt = run_r.id;
          if (total_r != '0) begin
            phase_nxt = dpas_pkg::PH_FINISH;
            state_nxt = dpas_pkg::ST_SCAN;
          end else begin
            busy_nxt  = 1'b0;
            run_nxt   = '0;
            state_nxt = dpas_pkg::ST_AGE;
          end
        end else begin
          run_nxt.rem  = run_r.rem - dpas_pkg::REM_W'(1);
          run_nxt.prio = dpas_pkg::sub_floor(run_r.prio, cfg.run_penalty);
          state_nxt    = dpas_pkg::ST_AGE;
        end
      end

      dpas_pkg::ST_AGE: begin
        if (dpas_pkg::CNT_W'(ptr_r) < total_r) begin
          list_wr.en        = 1'b1;
          list_wr.idx       = ptr_r;
          list_wr.data.id   = list_rd.id;
          list_wr.data.prio = dpas_pkg::age_prio(list_rd.prio, cfg.wait_bonus);
          list_wr.data.rem  = list_rd.rem;
        end
        if (last) begin
          state_nxt = dpas_pkg::ST_FLUSH;
        end else begin
          ptr_nxt = ptr_r + dpas_pkg::IDX_W'(1);
        end
      end

      dpas_pkg::ST_FLUSH: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = dpas_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = dpas_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res.accepted      = acc_r;
    res.done_valid    = done_r;
    res.done_id       = done_id_r;
    res.run_valid     = busy_r;
    res.run_id        = busy_r ? run_r.id : '0;
    res.run_priority  = busy_r ? run_r.prio : '0;
    res.run_remaining = busy_r ? run_r.rem : '0;
    res.waiting_count = 5'(total_r);
  end

  `DPAS_ASSERT(a_total_bound, clk, rst_n, total_r <= dpas_pkg::CNT_W'(dpas_pkg::MAX_WAITING), "ready list count overflow")
  `DPAS_ASSERT(a_idle_clean, clk, rst_n, busy_r || (run_r == '0), "stale running task while idle")
  `DPAS_ASSERT(a_run_work, clk, rst_n, !busy_r || (run_r.rem != '0), "running task with no work left")
  `DPAS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, (state_r == dpas_pkg::ST_IDLE) && in_valid, state_r != dpas_pkg::ST_IDLE, "accepted item not processed")

endmodule

/* sv/dynamic_priority_aging_scheduler.sv */
// Top level of the aging scheduler: configuration registers, output register,
// and the ready list plus sequencer. Depends on dpas_pkg, dpas_list, dpas_ctrl.
//
// Usage:
//   Input channel (in_valid / in_stall): one item per command. in_cmd = 0 is a
//   scheduler tick, in_cmd = 1 adds a task (in_task_id, in_start_priority,
//   in_burst_time) at the tail of a 16-entry ready list.
//   Output channel (out_valid / out_stall): exactly one result item per input
//   item, in order, with the running task and ready-list count after it.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 run
//   penalty, 1 wait bonus, 2 slice length; write only while the block is idle.
// Operation: one item at a time. A tick walks the ready list with one shared
//   compare/age unit, one entry per cycle: up to three pick scans and three
//   shift passes plus one aging pass.
// A finished result sits in the output register; the next item is taken
//   meanwhile, and its result waits until the receiver drops out_stall.
// Reset (synchronous, rst_n low) empties the list, clears the running task
//   and loads every configuration register with 1.
`timescale 1ns / 1ps

module dynamic_priority_aging_scheduler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_cmd,
  input  logic [dpas_pkg::ID_W-1:0]   in_task_id,
  input  logic [dpas_pkg::PRIO_W-1:0] in_start_priority,
  input  logic [dpas_pkg::REM_W-1:0]  in_burst_time,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_accepted,
  output logic                        out_done_valid,
  output logic [dpas_pkg::ID_W-1:0]   out_done_id,
  output logic                        out_run_valid,
  output logic [dpas_pkg::ID_W-1:0]   out_run_id,
  output logic [dpas_pkg::PRIO_W-1:0] out_run_priority,
  output logic [dpas_pkg::REM_W-1:0]  out_run_remaining,
  output logic [4:0]                  out_waiting_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [1:0]                  cfg_index,
  input  logic [7:0]                  cfg_data
);

  dpas_pkg::cfg_t     cfg_r, cfg_nxt;
  logic               out_valid_r, out_valid_nxt;
  dpas_pkg::res_t     out_r;
  dpas_pkg::res_t     res;
  logic               res_valid;
  logic               res_ready;
  dpas_pkg::idx_t     list_rd_idx;
  dpas_pkg::entry_t   list_rd;
  dpas_pkg::list_wr_t list_wr;

  assign cfg_ready = rst_n;
  assign res_ready = !out_valid_r || !out_stall;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dpas_pkg::REG_RUN_PENALTY:  cfg_nxt.run_penalty  = cfg_data[dpas_pkg::PRIO_W-1:0];
        dpas_pkg::REG_WAIT_BONUS:   cfg_nxt.wait_bonus   = cfg_data[dpas_pkg::PRIO_W-1:0];
        dpas_pkg::REG_SLICE_LENGTH: cfg_nxt.slice_length = cfg_data[dpas_pkg::SLICE_W-1:0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.run_penalty  <= dpas_pkg::PRIO_W'(1);
      cfg_r.wait_bonus   <= dpas_pkg::PRIO_W'(1);
      cfg_r.slice_length <= dpas_pkg::SLICE_W'(1);
      out_valid_r        <= 1'b0;
    end else begin
      cfg_r       <= cfg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // hold the result payload until the receiver takes it
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  dpas_list u_list (
    .clk     (clk),
    .rd_idx  (list_rd_idx),
    .rd_data (list_rd),
    .wr      (list_wr)
  );

  dpas_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_cmd            (in_cmd),
    .in_task_id        (in_task_id),
    .in_start_priority (in_start_priority),
    .in_burst_time     (in_burst_time),
    .cfg               (cfg_r),
    .res_valid         (res_valid),
    .res_ready         (res_ready),
    .res               (res),
    .list_rd_idx       (list_rd_idx),
    .list_rd           (list_rd),
    .list_wr           (list_wr)
  );

  assign out_valid         = out_valid_r;
  assign out_accepted      = out_r.accepted;
  assign out_done_valid    = out_r.done_valid;
  assign out_done_id       = out_r.done_id;
  assign out_run_valid     = out_r.run_valid;
  assign out_run_id        = out_r.run_id;
  assign out_run_priority  = out_r.run_priority;
  assign out_run_remaining = out_r.run_remaining;
  assign out_waiting_count = out_r.waiting_count;

endmodule
